>>> rtl/core/dtq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg
// shared sizes, codes and cell command type of the delta timer queue
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TASK_W      = 8;
  localparam int DELTA_W     = 16;
  localparam int WAIT_W      = 8;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 2;

  localparam logic [WAIT_W-1:0] WAIT_CAP = 8'd255;
  localparam logic [WAIT_W-1:0] IDLE_WAIT_RESET = 8'd255;

  // request codes
  localparam logic [REQ_W-1:0] REQ_SCHEDULE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CANCEL   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK     = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_SET_DELTA
  } cell_op_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   pos;
    logic [TASK_W-1:0]  tid;
    logic [DELTA_W-1:0] delta;
    logic               adj;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> rtl/core/dtq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_cell
// one queue slot: task id and delta, shifts to or from its neighbors
// ----------------------------------------------------------------------------
module dtq_cell (
  input  wire logic                       clk_i,
  input  wire logic [dtq_pkg::IDX_W-1:0]  cell_idx_i,
  input  wire dtq_pkg::cell_cmd_t         cmd_i,
  input  wire logic [dtq_pkg::TASK_W-1:0] prev_tid_i,
  input  wire logic [dtq_pkg::DELTA_W-1:0] prev_delta_i,
  input  wire logic [dtq_pkg::TASK_W-1:0] next_tid_i,
  input  wire logic [dtq_pkg::DELTA_W-1:0] next_delta_i,
  output logic      [dtq_pkg::TASK_W-1:0] tid_o,
  output logic      [dtq_pkg::DELTA_W-1:0] delta_o
);
  import dtq_pkg::*;

  logic [TASK_W-1:0]  tid_q, tid_d;
  logic [DELTA_W-1:0] delta_q, delta_d;
  logic               at_pos, after_pos, just_after;
  logic [DELTA_W:0]   sum;
  logic [DELTA_W-1:0] sum_sat, diff;

  assign at_pos     = (cell_idx_i == cmd_i.pos);
  assign after_pos  = (cell_idx_i > cmd_i.pos);
  assign just_after = after_pos && ({1'b0, cell_idx_i} == ({1'b0, cmd_i.pos} + 1'b1));

  // merged delta when this slot's entry is removed
  assign sum     = {1'b0, next_delta_i} + {1'b0, delta_q};
  assign sum_sat = sum[DELTA_W] ? {DELTA_W{1'b1}} : sum[DELTA_W-1:0];
  // displaced entry keeps what is left past the new one
  assign diff    = prev_delta_i - cmd_i.delta;

  always_comb begin
    tid_d   = tid_q;
    delta_d = delta_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (at_pos) begin
          tid_d   = cmd_i.tid;
          delta_d = cmd_i.delta;
        end else if (after_pos) begin
          tid_d   = prev_tid_i;
          delta_d = (just_after && cmd_i.adj) ? diff : prev_delta_i;
        end
      end
      OP_REMOVE: begin
        if (at_pos) begin
          tid_d   = next_tid_i;
          delta_d = cmd_i.adj ? sum_sat : next_delta_i;
        end else if (after_pos) begin
          tid_d   = next_tid_i;
          delta_d = next_delta_i;
        end
      end
      OP_SET_DELTA: begin
        if (at_pos) begin
          delta_d = cmd_i.delta;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    tid_q   <= tid_d;
    delta_q <= delta_d;
  end

  assign tid_o   = tid_q;
  assign delta_o = delta_q;

endmodule
`default_nettype wire

>>> rtl/core/dtq_chain.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_chain
// row of queue slots, slot 0 is the head
// ----------------------------------------------------------------------------
module dtq_chain (
  input  wire logic                  clk_i,
  input  wire dtq_pkg::cell_cmd_t    cmd_i,
  output logic [dtq_pkg::TASK_W-1:0] tid_o   [dtq_pkg::QUEUE_DEPTH],
  output logic [dtq_pkg::DELTA_W-1:0] delta_o [dtq_pkg::QUEUE_DEPTH]
);
  import dtq_pkg::*;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [TASK_W-1:0]  prev_tid, next_tid;
    logic [DELTA_W-1:0] prev_delta, next_delta;

    if (i == 0) begin : g_first
      assign prev_tid   = '0;
      assign prev_delta = '0;
    end else begin : g_mid_prev
      assign prev_tid   = tid_o[i-1];
      assign prev_delta = delta_o[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_tid   = '0;
      assign next_delta = '0;
    end else begin : g_mid_next
      assign next_tid   = tid_o[i+1];
      assign next_delta = delta_o[i+1];
    end

    dtq_cell u_cell (
      .clk_i        (clk_i),
      .cell_idx_i   (IDX_W'(i)),
      .cmd_i        (cmd_i),
      .prev_tid_i   (prev_tid),
      .prev_delta_i (prev_delta),
      .next_tid_i   (next_tid),
      .next_delta_i (next_delta),
      .tid_o        (tid_o[i]),
      .delta_o      (delta_o[i])
    );
  end

endmodule
`default_nettype wire

>>> rtl/core/delta_timer_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delta_timer_queue
// delay-ordered queue of task ids kept as a delta list in a row of slots
// ----------------------------------------------------------------------------
// sequence: a cancel goes through the cancel and response states; a schedule
//   checks duplicate, zero delay and full, then walks the slots and inserts;
//   a tick walks the due entries, then delivers and pops each one in turn;
//   an unknown request goes straight to the response; output stalls hold results
// one item at a time: no new request is taken until the current one is done
// reset: queue empty (count cleared), idle wait 255; slots need no clearing
// ----------------------------------------------------------------------------
module delta_timer_queue (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [dtq_pkg::WAIT_W-1:0]    cfg_wdata_i,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [dtq_pkg::REQ_W-1:0]     req_type_i,
  input  wire logic [dtq_pkg::TASK_W-1:0]    task_id_i,
  input  wire logic [dtq_pkg::DELTA_W-1:0]   delay_i,
  input  wire logic [dtq_pkg::DELTA_W-1:0]   elapsed_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               ready_valid_o,
  output logic      [dtq_pkg::TASK_W-1:0]    ready_task_o,
  output logic      [dtq_pkg::STATUS_W-1:0]  status_o,
  output logic      [dtq_pkg::WAIT_W-1:0]    next_wait_o,
  output logic                               last_o
);
  import dtq_pkg::*;

  // controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCHED  = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_CANCEL = 3'd3;
  localparam logic [2:0] S_TICK   = 3'd4;
  localparam logic [2:0] S_POP    = 3'd5;
  localparam logic [2:0] S_RESP   = 3'd6;

  // head delta clamped to the wait range, idle wait when empty, never zero
  function automatic logic [WAIT_W-1:0] wait_of(input logic occupied,
                                                input logic [DELTA_W-1:0] d,
                                                input logic [WAIT_W-1:0] idle);
    logic [WAIT_W-1:0] w;
    if (!occupied) begin
      w = idle;
    end else if (d > DELTA_W'(WAIT_CAP)) begin
      w = WAIT_CAP;
    end else begin
      w = d[WAIT_W-1:0];
    end
    if (w == '0) begin
      w = WAIT_W'(1);
    end
    return w;
  endfunction

  logic [2:0]          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;       // walk position, later release count
  logic [CNT_W-1:0]    pop_q, pop_d;       // releases delivered so far
  logic [DELTA_W-1:0]  rem_q, rem_d;       // delay or elapsed still to cover
  logic [TASK_W-1:0]   id_q, id_d;
  logic [WAIT_W-1:0]   idle_wait_q;
  logic [WAIT_W-1:0]   nw_q, nw_d;         // final wait of a releasing tick

  // pending single result
  logic                rv_q, rv_d;
  logic [TASK_W-1:0]   rt_q, rt_d;
  logic [STATUS_W-1:0] st_q, st_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic                out_rv_q, out_rv_d;
  logic [TASK_W-1:0]   out_tid_q, out_tid_d;
  logic [STATUS_W-1:0] out_st_q, out_st_d;
  logic [WAIT_W-1:0]   out_nw_q, out_nw_d;
  logic                out_last_q, out_last_d;
  logic                out_free;

  cell_cmd_t           cmd;
  logic [TASK_W-1:0]   slot_tid   [QUEUE_DEPTH];
  logic [DELTA_W-1:0]  slot_delta [QUEUE_DEPTH];

  logic                in_accept;
  logic                occ;
  logic [IDX_W-1:0]    idx_slot;
  logic [DELTA_W-1:0]  cur_delta;
  logic [QUEUE_DEPTH-1:0] hit;
  logic                found;
  logic [IDX_W-1:0]    hit_pos;

  // the slot chain holds the queue; the controller only broadcasts commands
  dtq_chain u_chain (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .tid_o   (slot_tid),
    .delta_o (slot_delta)
  );

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  // slot under the walk pointer
  assign idx_slot  = idx_q[IDX_W-1:0];
  assign occ       = (idx_q < count_q);
  assign cur_delta = slot_delta[idx_slot];

  // id lookup over the occupied slots, ids are unique so first hit is the only one
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      hit[i] = (slot_tid[i] == id_q) && (CNT_W'(i) < count_q);
    end
    found   = |hit;
    hit_pos = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_pos = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    pop_d   = pop_q;
    rem_d   = rem_q;
    id_d    = id_q;
    nw_d    = nw_q;
    rv_d    = rv_q;
    rt_d    = rt_q;
    st_d    = st_q;

    cmd       = '0;
    cmd.op    = OP_HOLD;

    out_valid_d = out_valid_q && out_stall_i;
    out_rv_d    = out_rv_q;
    out_tid_d   = out_tid_q;
    out_st_d    = out_st_q;
    out_nw_d    = out_nw_q;
    out_last_d  = out_last_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          id_d  = task_id_i;
          idx_d = '0;
          pop_d = '0;
          rv_d  = 1'b0;
          rt_d  = '0;
          st_d  = ST_OK;
          case (req_type_i)
            REQ_SCHEDULE: begin
              rem_d   = delay_i;
              state_d = S_SCHED;
            end
            REQ_CANCEL: begin
              state_d = S_CANCEL;
            end
            REQ_TICK: begin
              rem_d   = elapsed_i;
              state_d = S_TICK;
            end
            default: begin
              // unknown request: plain ok result
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_SCHED: begin
        if (found) begin
          st_d    = ST_DUPLICATE;
          state_d = S_RESP;
        end else if (rem_q == '0) begin
          // zero delay releases at once
          rv_d    = 1'b1;
          rt_d    = id_q;
          state_d = S_RESP;
        end else if (count_q >= CNT_W'(QUEUE_DEPTH)) begin
          st_d    = ST_FULL;
          state_d = S_RESP;
        end else begin
          state_d = S_WALK;
        end
      end

      S_WALK: begin
        if (!occ || (cur_delta > rem_q)) begin
          // insert here; the displaced entry keeps the remainder of its delta
          cmd.op    = OP_INSERT;
          cmd.pos   = idx_slot;
          cmd.tid   = id_q;
          cmd.delta = rem_q;
          cmd.adj   = occ;
          count_d   = count_q + 1'b1;
          state_d   = S_RESP;
        end else begin
          rem_d = rem_q - cur_delta;
          idx_d = idx_q + 1'b1;
        end
      end

      S_CANCEL: begin
        if (found) begin
          // the successor absorbs the removed delta
          cmd.op  = OP_REMOVE;
          cmd.pos = hit_pos;
          cmd.adj = ({1'b0, hit_pos} + 1'b1) < (IDX_W + 1)'(count_q);
          count_d = count_q - 1'b1;
        end else begin
          st_d = ST_NOT_FOUND;
        end
        state_d = S_RESP;
      end

      S_TICK: begin
        // first pass: count the due entries and fix up the new head
        if (!occ || (cur_delta > rem_q) || (int'(idx_q) >= MAX_RESULTS)) begin
          if (!occ) begin
            // queue drains, excess time is dropped
            nw_d = wait_of(1'b0, '0, idle_wait_q);
          end else if (cur_delta > rem_q) begin
            cmd.op    = OP_SET_DELTA;
            cmd.pos   = idx_slot;
            cmd.delta = cur_delta - rem_q;
            nw_d      = wait_of(1'b1, cur_delta - rem_q, idle_wait_q);
          end else begin
            // release limit hit: the rest fall due on the next tick
            cmd.op    = OP_SET_DELTA;
            cmd.pos   = idx_slot;
            cmd.delta = '0;
            nw_d      = wait_of(1'b1, '0, idle_wait_q);
          end
          state_d = (idx_q == '0) ? S_RESP : S_POP;
        end else begin
          rem_d = rem_q - cur_delta;
          idx_d = idx_q + 1'b1;
        end
      end

      S_POP: begin
        // second pass: deliver the head and pop it, once per free output slot
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rv_d    = 1'b1;
          out_tid_d   = slot_tid[0];
          out_st_d    = ST_OK;
          out_nw_d    = nw_q;
          out_last_d  = (pop_q == (idx_q - 1'b1));
          cmd.op      = OP_REMOVE;
          cmd.pos     = '0;
          cmd.adj     = 1'b0;
          count_d     = count_q - 1'b1;
          pop_d       = pop_q + 1'b1;
          if (pop_q == (idx_q - 1'b1)) begin
            state_d = S_IDLE;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rv_d    = rv_q;
          out_tid_d   = rt_q;
          out_st_d    = st_q;
          out_nw_d    = wait_of(count_q != '0, slot_delta[0], idle_wait_q);
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idle_wait_q <= IDLE_WAIT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        idle_wait_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    pop_q      <= pop_d;
    rem_q      <= rem_d;
    id_q       <= id_d;
    nw_q       <= nw_d;
    rv_q       <= rv_d;
    rt_q       <= rt_d;
    st_q       <= st_d;
    out_rv_q   <= out_rv_d;
    out_tid_q  <= out_tid_d;
    out_st_q   <= out_st_d;
    out_nw_q   <= out_nw_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign ready_valid_o = out_rv_q;
  assign ready_task_o  = out_tid_q;
  assign status_o      = out_st_q;
  assign next_wait_o   = out_nw_q;
  assign last_o        = out_last_q;

  // the queue never holds more than its depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // a result that is not the last one leaves the block busy
  a_busy_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |-> in_stall_o)
    else $error("block idle before last result of an item");

  // error status only on a single, non-releasing result
  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_o && !ready_valid_o)
    else $error("error status on a release or multi-result item");

  // reported wait is never zero
  a_wait_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> next_wait_o != '0)
    else $error("zero next wait reported");

  // a silent result carries no task id
  a_idle_task_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ready_valid_o |-> ready_task_o == '0)
    else $error("task id on a result without release");

endmodule
`default_nettype wire

>>> sim/dtq_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtq_result_checker
// watches the request and result channels of the delta timer queue, keeps
// its own delta list to work out the due results, compares them in order
// ----------------------------------------------------------------------------
module dtq_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dtq_pkg::WAIT_W-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [dtq_pkg::REQ_W-1:0]     req_type_i,
  input  logic [dtq_pkg::TASK_W-1:0]    task_id_i,
  input  logic [dtq_pkg::DELTA_W-1:0]   delay_i,
  input  logic [dtq_pkg::DELTA_W-1:0]   elapsed_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          ready_valid_i,
  input  logic [dtq_pkg::TASK_W-1:0]    ready_task_i,
  input  logic [dtq_pkg::STATUS_W-1:0]  status_i,
  input  logic [dtq_pkg::WAIT_W-1:0]    next_wait_i,
  input  logic                          last_i,
  output int                            pending_o,
  output int                            fail_count_o
);
  import dtq_pkg::*;

  typedef struct packed {
    logic                ready_valid;
    logic [TASK_W-1:0]   ready_task;
    logic [STATUS_W-1:0] status;
    logic [WAIT_W-1:0]   next_wait;
    logic                last;
  } due_result_t;

  // shadow delta list, slot 0 is the head
  logic [TASK_W-1:0]  shadow_task  [QUEUE_DEPTH];
  logic [DELTA_W-1:0] shadow_delta [QUEUE_DEPTH];
  int                 shadow_count;
  logic [WAIT_W-1:0]  idle_wait_q;

  due_result_t        due_results_q [$];
  due_result_t        oldest_due;
  int                 fails;

  function automatic int find_slot(logic [TASK_W-1:0] id);
    for (int i = 0; i < shadow_count; i++)
      if (shadow_task[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < shadow_count; i++) begin
      shadow_task[i]  = shadow_task[i+1];
      shadow_delta[i] = shadow_delta[i+1];
    end
    shadow_count--;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  // works out every result of one request and queues them
  task automatic predict_request(input logic [REQ_W-1:0] req, input logic [TASK_W-1:0] id,
                                 input logic [DELTA_W-1:0] dly,
                                 input logic [DELTA_W-1:0] elap);
    due_result_t        res;
    due_result_t        batch [$];
    int                 pos;
    logic [DELTA_W-1:0] rest;
    logic [DELTA_W:0]   sum;
    logic [WAIT_W-1:0]  nxt;
    res = '0;
    case (req)
      REQ_SCHEDULE: begin
        if (find_slot(id) >= 0) begin
          res.status = ST_DUPLICATE;
        end else if (dly == 0) begin
          // due at once, never enters the list
          res.ready_valid = 1'b1;
          res.ready_task  = id;
        end else if (shadow_count >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          rest = dly;
          pos  = 0;
          while (pos < shadow_count) begin
            if (shadow_delta[pos] > rest) begin
              shadow_delta[pos] = shadow_delta[pos] - rest;
              break;
            end
            rest = rest - shadow_delta[pos];
            pos++;
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_task[i]  = shadow_task[i-1];
            shadow_delta[i] = shadow_delta[i-1];
          end
          shadow_task[pos]  = id;
          shadow_delta[pos] = rest;
          shadow_count++;
        end
        batch.push_back(res);
      end
      REQ_CANCEL: begin
        pos = find_slot(id);
        if (pos < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          // successor inherits the removed delta, saturating
          if (pos + 1 < shadow_count) begin
            sum = {1'b0, shadow_delta[pos+1]} + shadow_delta[pos];
            shadow_delta[pos+1] = sum[DELTA_W] ? '1 : sum[DELTA_W-1:0];
          end
          drop_slot(pos);
        end
        batch.push_back(res);
      end
      REQ_TICK: begin
        rest = elap;
        while (shadow_count > 0) begin
          if (shadow_delta[0] > rest) begin
            shadow_delta[0] = shadow_delta[0] - rest;
            break;
          end
          if (batch.size() >= MAX_RESULTS) begin
            shadow_delta[0] = '0;
            break;
          end
          rest = rest - shadow_delta[0];
          res.ready_valid = 1'b1;
          res.ready_task  = shadow_task[0];
          batch.push_back(res);
          drop_slot(0);
        end
        // nothing due, res is still all zero
        if (batch.size() == 0) batch.push_back(res);
      end
      default: batch.push_back(res);
    endcase

    if (shadow_count > 0)
      nxt = (shadow_delta[0] > WAIT_CAP) ? WAIT_CAP : shadow_delta[0][WAIT_W-1:0];
    else
      nxt = idle_wait_q;
    if (nxt == 0) nxt = 8'd1;
    for (int k = 0; k < batch.size(); k++) begin
      batch[k].next_wait = nxt;
      batch[k].last      = (k == batch.size() - 1);
      due_results_q.push_back(batch[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_count = 0;
      idle_wait_q  = IDLE_WAIT_RESET;
      due_results_q.delete();
      fails = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // results leaving now belong to earlier requests, so compare first
      if (out_valid_i && !out_stall_i) begin
        if (due_results_q.size() == 0) begin
          $error("unexpected result: ready_task %0d, status %0d", ready_task_i, status_i);
          fails++;
        end else begin
          oldest_due = due_results_q.pop_front();
          check_field("ready_valid", oldest_due.ready_valid, ready_valid_i);
          check_field("ready_task", oldest_due.ready_task, ready_task_i);
          check_field("status", oldest_due.status, status_i);
          check_field("next_wait", oldest_due.next_wait, next_wait_i);
          check_field("last", oldest_due.last, last_i);
        end
      end
      if (cfg_we_i) idle_wait_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i)
        predict_request(req_type_i, task_id_i, delay_i, elapsed_i);
      pending_o    <= due_results_q.size();
      fail_count_o <= fails;
    end
  end

endmodule

>>> sim/tb_delta_timer_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delta_timer_queue
// drives requests into the delta timer queue (a directed opening, then
// random phases with different idle and stall patterns and idle wait
// settings); the result checker beside the block predicts and compares
// ----------------------------------------------------------------------------
module tb_delta_timer_queue;
  import dtq_pkg::*;

  localparam int RESET_CYCLES = 6;
  // longest walk: schedule/tick over all slots plus delivery of every release
  localparam int DRAIN_CYCLES = 48;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_ITEMS  = 31;
  localparam int NUM_PHASES   = 4;
  // code the block has no use for, must come back as a plain ok
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [WAIT_W-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic [REQ_W-1:0]    req_type_i  = REQ_SCHEDULE;
  logic [TASK_W-1:0]   task_id_i   = '0;
  logic [DELTA_W-1:0]  delay_i     = '0;
  logic [DELTA_W-1:0]  elapsed_i   = '0;
  logic                out_stall_i = 1'b0;

  logic                in_stall_o;
  logic                out_valid_o;
  logic                ready_valid_o;
  logic [TASK_W-1:0]   ready_task_o;
  logic [STATUS_W-1:0] status_o;
  logic [WAIT_W-1:0]   next_wait_o;
  logic                last_o;

  int pending;
  int fail_count;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycle_cnt      = 0;

  delta_timer_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .task_id_i     (task_id_i),
    .delay_i       (delay_i),
    .elapsed_i     (elapsed_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ready_valid_o (ready_valid_o),
    .ready_task_o  (ready_task_o),
    .status_o      (status_o),
    .next_wait_o   (next_wait_o),
    .last_o        (last_o)
  );

  dtq_result_checker checker_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .req_type_i    (req_type_i),
    .task_id_i     (task_id_i),
    .delay_i       (delay_i),
    .elapsed_i     (elapsed_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ready_valid_i (ready_valid_o),
    .ready_task_i  (ready_task_o),
    .status_i      (status_o),
    .next_wait_i   (next_wait_o),
    .last_i        (last_o),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always #2 clk_i = ~clk_i;

  // result side back-pressure, random per cycle at the phase's rate
  always @(posedge clk_i) begin
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // presents one item and returns at the edge that accepts it; an idle gap
  // drops valid first, otherwise valid stays high from the previous item
  task automatic send_item(input logic [REQ_W-1:0] req, input logic [TASK_W-1:0] id,
                           input logic [DELTA_W-1:0] dly, input logic [DELTA_W-1:0] elap);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    task_id_i  <= id;
    delay_i    <= dly;
    elapsed_i  <= elap;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // sender holds off until every due result has come out, then lets the
  // block settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_idle_wait(input logic [WAIT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int                 roll;
    logic [REQ_W-1:0]   req;
    logic [TASK_W-1:0]  id;
    logic [DELTA_W-1:0] dly;
    logic [DELTA_W-1:0] elap;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening, smallest idle wait, no idling
    write_idle_wait(8'd1);
    // zero delay releases at once
    send_item(REQ_SCHEDULE, 8'd0, 16'd0, 16'd0);
    // largest delay, head wait clamps at 255
    send_item(REQ_SCHEDULE, 8'd255, 16'hFFFF, 16'hFFFF);
    // duplicate id wins over zero delay
    send_item(REQ_SCHEDULE, 8'd255, 16'd0, 16'd0);
    // tick with nothing due
    send_item(REQ_TICK, 8'd0, 16'd0, 16'd0);
    // cancel of an absent id
    send_item(REQ_CANCEL, 8'd7, 16'd0, 16'd0);
    // unused request code
    send_item(REQ_UNUSED, 8'd255, 16'hFFFF, 16'hFFFF);
    // cancel the only entry, queue back to empty
    send_item(REQ_CANCEL, 8'd255, 16'd0, 16'd0);
    // fill every slot; the first two share a due time so the second has delta 0
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      send_item(REQ_SCHEDULE, 8'(32 + k),
                (k < 2) ? 16'd3 : ((k == QUEUE_DEPTH - 1) ? 16'd60000 : 16'(10 + k * 23)),
                16'd0);
    end
    // full queue rejects a nonzero delay
    send_item(REQ_SCHEDULE, 8'd100, 16'd9, 16'd0);
    // removing the head passes its delta to the zero-delta successor, wait reports 3
    send_item(REQ_CANCEL, 8'd32, 16'd0, 16'd0);
    // release everything, the leftover time is dropped
    send_item(REQ_TICK, 8'd0, 16'd0, 16'hFFFF);
    wait_drained();

    // random phases: idling pattern and idle wait change only while idle
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          write_idle_wait(8'd255);
        end
        1: begin
          send_idle_pct = 77; recv_stall_pct = 0;
          write_idle_wait(8'($urandom_range(2, 254)));
        end
        2: begin
          send_idle_pct = 0;  recv_stall_pct = 77;
          write_idle_wait(8'd1);
        end
        default: begin
          send_idle_pct = 7;  recv_stall_pct = 7;
          write_idle_wait(8'd200);
        end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mid-phase hold-off until the queue of results runs dry
        if (n == PHASE_ITEMS / 2) wait_drained();

        // small id pool so duplicates and successful cancels are common
        if ($urandom_range(9) == 0) id = 8'($urandom_range(255));
        else id = 8'($urandom_range(23));

        roll = $urandom_range(99);
        if (roll < 5) dly = 16'd0;
        else if (roll < 15) dly = 16'($urandom_range(65535));
        else dly = 16'($urandom_range(1, 400));

        // large ticks are rare, otherwise the list never fills up
        roll = $urandom_range(99);
        if (roll < 8) elap = 16'd0;
        else if (roll < 11) elap = 16'($urandom_range(65535));
        else elap = 16'($urandom_range(1, 150));

        roll = $urandom_range(99);
        if (roll < 45) req = REQ_SCHEDULE;
        else if (roll < 65) req = REQ_CANCEL;
        else if (roll < 99) req = REQ_TICK;
        else req = REQ_UNUSED;

        send_item(req, id, dly, elap);
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
